/* src/hrc_pkg.sv */
// Shared types, constants and codes of the reflectance conversion block.
`default_nettype none
package hrc_pkg;

  localparam int REF_DEPTH = 64;
  localparam int CHANNELS  = 256;
  localparam int REF_AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // pixel scale: 3.14 * 1000 with Q.8 on the numerator
  localparam int PIX_SCALE = 3140 * 256;
  localparam int ALB_MAX   = 1000;

  // shared divider widths
  localparam int DIV_W  = 49;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CHAN = 2'd1,
    OP_PIX  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_LOAD  = 3'd1,
    K_CHAN  = 3'd2,
    K_PIX   = 3'd3,
    K_BADCH = 3'd4
  } kind_t;

  typedef struct packed {
    logic [15:0]        wl;
    logic signed [23:0] pr;
    logic [31:0]        edir;
    logic [31:0]        edn;
    logic [15:0]        tau;
  } ref_ent_t;

  typedef struct packed {
    logic signed [23:0] offset;
    logic [31:0]        gain;
  } chan_ent_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         index;
    logic [15:0]        wl;
    logic signed [23:0] pr;
    logic [31:0]        edir;
    logic [31:0]        edn;
    logic [15:0]        tau;
    logic signed [15:0] raw;
  } cmd_t;

  typedef struct packed {
    logic [9:0] albedo;
    status_t    status;
  } res_t;

endpackage
`default_nettype wire

/* src/hrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/hrc_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module hrc_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [hrc_pkg::DIV_W-1:0]      dividend,
  input  wire logic [hrc_pkg::DIV_DW-1:0]     divisor,
  output logic                                done,
  output logic      [hrc_pkg::DIV_W-1:0]      quotient
);

  logic [hrc_pkg::DIV_W-1:0]  q;
  logic [hrc_pkg::DIV_DW-1:0] rem;
  logic [hrc_pkg::DIV_DW-1:0] dvs;
  logic [hrc_pkg::DIV_CW-1:0] cnt;
  logic                       running;
  logic [hrc_pkg::DIV_DW:0]   rem_sh;
  logic                       fits;

  assign rem_sh   = {rem, q[hrc_pkg::DIV_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= hrc_pkg::DIV_CW'(hrc_pkg::DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == hrc_pkg::DIV_CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      q   <= {q[hrc_pkg::DIV_W-2:0], fits};
      rem <= fits ? hrc_pkg::DIV_DW'(rem_sh - {1'b0, dvs}) : rem_sh[hrc_pkg::DIV_DW-1:0];
    end
  end

endmodule
`default_nettype wire

/* src/hrc_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module hrc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         op,
  input  wire logic [7:0]         index,
  input  wire logic [15:0]        wavelength,
  input  wire logic signed [23:0] path_radiance,
  input  wire logic [31:0]        direct_irradiance,
  input  wire logic [31:0]        diffuse_irradiance,
  input  wire logic [15:0]        transmittance,
  input  wire logic signed [15:0] raw_pixel,
  output logic                    q_valid,
  output hrc_pkg::cmd_t           q_cmd,
  input  wire logic               q_take
);

  hrc_pkg::cmd_t cmd_in;
  hrc_pkg::cmd_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push_ok;
  logic          take_ok;
  logic          ch_ok;

  assign ch_ok = int'(index) < hrc_pkg::CHANNELS;

  always_comb begin
    cmd_in       = '0;
    cmd_in.index = index;
    cmd_in.wl    = wavelength;
    cmd_in.pr    = path_radiance;
    cmd_in.edir  = direct_irradiance;
    cmd_in.edn   = diffuse_irradiance;
    cmd_in.tau   = transmittance;
    cmd_in.raw   = raw_pixel;
    case (hrc_pkg::op_t'(op))
      hrc_pkg::OP_LOAD: begin
        cmd_in.kind = (int'(index) < hrc_pkg::REF_DEPTH) ? hrc_pkg::K_LOAD : hrc_pkg::K_NOP;
      end
      hrc_pkg::OP_CHAN: cmd_in.kind = ch_ok ? hrc_pkg::K_CHAN : hrc_pkg::K_BADCH;
      hrc_pkg::OP_PIX:  cmd_in.kind = ch_ok ? hrc_pkg::K_PIX : hrc_pkg::K_BADCH;
      default:          cmd_in.kind = hrc_pkg::K_NOP;
    endcase
  end

  assign full    = count == 2'd2;
  assign q_valid = count != 2'd0;
  assign q_cmd   = slot[rd_ptr];
  assign push_ok = push && !full;
  assign take_ok = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (take_ok) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push_ok} - {1'b0, take_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

/* src/hrc_back.sv */
// Back end: reference table, channel table, interpolation and pixel conversion.
`default_nettype none
module hrc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [6:0]    ref_count,
  input  wire logic          q_valid,
  input  wire hrc_pkg::cmd_t q_cmd,
  output logic               q_take,
  output logic               res_valid,
  output hrc_pkg::res_t      res,
  input  wire logic          res_ready
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_PRD    = 13'h0002,
    S_PSTART = 13'h0004,
    S_PWAIT  = 13'h0008,
    S_CW0    = 13'h0010,
    S_CWL    = 13'h0020,
    S_SCAN   = 13'h0040,
    S_LMUL   = 13'h0080,
    S_LSTART = 13'h0100,
    S_LWAIT  = 13'h0200,
    S_GAIN   = 13'h0400,
    S_GFIN   = 13'h0800,
    S_RESP   = 13'h1000
  } state_t;

  state_t                        state;
  hrc_pkg::cmd_t                 cmd;
  hrc_pkg::ref_ent_t             lo;
  hrc_pkg::ref_ent_t             hi;
  hrc_pkg::ref_ent_t             ref_rd;
  hrc_pkg::chan_ent_t            chan_rd;
  hrc_pkg::chan_ent_t            chan_wr;
  logic [hrc_pkg::REF_AW-1:0]    k;
  logic [hrc_pkg::REF_AW-1:0]    last;
  logic [hrc_pkg::REF_AW-1:0]    ref_raddr;
  logic [hrc_pkg::CH_AW-1:0]     ch_addr;
  logic [hrc_pkg::CH_AW-1:0]     q_ch_addr;
  logic [hrc_pkg::CHANNELS-1:0]  chan_valid;
  logic                          ref_we;
  logic                          chan_we;
  logic [1:0]                    j;
  logic signed [23:0]            off_v;
  logic [31:0]                   edir_v;
  logic [31:0]                   edn_v;
  logic [15:0]                   tau_v;
  logic signed [32:0]            d0;
  logic signed [32:0]            d1;
  logic signed [32:0]            dd;
  logic [32:0]                   dd_abs;
  logic [15:0]                   span;
  logic [15:0]                   dx;
  logic [47:0]                   prod;
  logic                          neg;
  logic signed [33:0]            lv;
  logic [48:0]                   p;
  logic [32:0]                   g;
  logic signed [24:0]            diff;
  logic [43:0]                   num;
  logic [31:0]                   gain;
  logic                          div_start;
  logic [hrc_pkg::DIV_W-1:0]     div_dividend;
  logic [hrc_pkg::DIV_DW-1:0]    div_divisor;
  logic                          div_done;
  logic [hrc_pkg::DIV_W-1:0]     div_quot;
  int                            n;

  // clamp point count to 2..REF_DEPTH
  always_comb begin
    n = int'(ref_count);
    if (n < 2) begin
      n = 2;
    end
    if (n > hrc_pkg::REF_DEPTH) begin
      n = hrc_pkg::REF_DEPTH;
    end
    last = hrc_pkg::REF_AW'(n - 1);
  end

  assign ch_addr   = hrc_pkg::CH_AW'(cmd.index);
  assign q_ch_addr = hrc_pkg::CH_AW'(q_cmd.index);
  assign q_take    = (state == S_IDLE) && q_valid;
  assign res_valid = state == S_RESP;
  assign ref_we    = q_take && (q_cmd.kind == hrc_pkg::K_LOAD);

  always_comb begin
    case (state)
      S_CW0:   ref_raddr = last;
      S_CWL:   ref_raddr = last - 1'b1;
      S_SCAN:  ref_raddr = k - 1'b1;
      default: ref_raddr = '0;
    endcase
  end

  hrc_ram #(
    .WIDTH ($bits(hrc_pkg::ref_ent_t)),
    .DEPTH (hrc_pkg::REF_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (hrc_pkg::REF_AW'(q_cmd.index)),
    .wdata ({q_cmd.wl, q_cmd.pr, q_cmd.edir, q_cmd.edn, q_cmd.tau}),
    .raddr (ref_raddr),
    .rdata (ref_rd)
  );

  hrc_ram #(
    .WIDTH ($bits(hrc_pkg::chan_ent_t)),
    .DEPTH (hrc_pkg::CHANNELS)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (ch_addr),
    .wdata (chan_wr),
    .raddr (q_ch_addr),
    .rdata (chan_rd)
  );

  hrc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // interpolation operands of the current quantity
  always_comb begin
    case (j)
      2'd0: begin
        d0 = 33'(lo.pr);
        d1 = 33'(hi.pr);
      end
      2'd1: begin
        d0 = $signed({1'b0, lo.edir});
        d1 = $signed({1'b0, hi.edir});
      end
      2'd2: begin
        d0 = $signed({1'b0, lo.edn});
        d1 = $signed({1'b0, hi.edn});
      end
      default: begin
        d0 = $signed({17'b0, lo.tau});
        d1 = $signed({17'b0, hi.tau});
      end
    endcase
    dd     = d1 - d0;
    dd_abs = dd[32] ? 33'(-dd) : 33'(dd);
    span   = hi.wl - lo.wl;
    dx     = cmd.wl - lo.wl;
    lv     = 34'(d0) + (neg ? -34'(div_quot[32:0]) : 34'(div_quot[32:0]));
    diff   = $signed({cmd.raw[15], cmd.raw, 8'h00}) - 25'(chan_rd.offset);
    g      = p[48:16];
    chan_wr.offset = off_v;
    if (g[32]) begin
      chan_wr.gain = 32'hFFFF_FFFF;
    end else if (g == '0) begin
      chan_wr.gain = 32'd1;
    end else begin
      chan_wr.gain = g[31:0];
    end
  end

  assign chan_we   = (state == S_GFIN) && (p != '0);
  assign div_start = (state == S_LSTART) || (state == S_PSTART);

  always_comb begin
    if (state == S_PSTART) begin
      div_dividend = hrc_pkg::DIV_W'(num);
      div_divisor  = gain;
    end else begin
      div_dividend = hrc_pkg::DIV_W'(prod);
      div_divisor  = hrc_pkg::DIV_DW'(span);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      chan_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              hrc_pkg::K_CHAN: begin
                chan_valid[q_ch_addr] <= 1'b0;
                state <= S_CW0;
              end
              hrc_pkg::K_PIX: begin
                state <= chan_valid[q_ch_addr] ? S_PRD : S_RESP;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_PRD: begin
          if (chan_rd.gain == '0 || diff[24] || diff == '0) begin
            state <= S_RESP;
          end else begin
            state <= S_PSTART;
          end
        end
        S_PSTART: state <= S_PWAIT;
        S_PWAIT:  state <= div_done ? S_RESP : S_PWAIT;
        S_CW0:    state <= (cmd.wl < ref_rd.wl) ? S_RESP : S_CWL;
        S_CWL:    state <= (cmd.wl > ref_rd.wl) ? S_RESP : S_SCAN;
        S_SCAN: begin
          if (cmd.wl <= hi.wl && cmd.wl >= ref_rd.wl) begin
            state <= S_LMUL;
          end else if (k == '0) begin
            state <= S_RESP;
          end
        end
        S_LMUL: begin
          if (span == '0) begin
            state <= (j == 2'd3) ? S_GAIN : S_LMUL;
          end else begin
            state <= S_LSTART;
          end
        end
        S_LSTART: state <= S_LWAIT;
        S_LWAIT: begin
          if (div_done) begin
            state <= (j == 2'd3) ? S_GAIN : S_LMUL;
          end
        end
        S_GAIN: state <= S_GFIN;
        S_GFIN: begin
          if (p != '0) begin
            chan_valid[ch_addr] <= 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: state <= res_ready ? S_IDLE : S_RESP;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd        <= q_cmd;
        res.albedo <= '0;
        res.status <= (q_cmd.kind == hrc_pkg::K_BADCH ||
                       (q_cmd.kind == hrc_pkg::K_PIX && !chan_valid[q_ch_addr]))
                      ? hrc_pkg::ST_INVALID : hrc_pkg::ST_OK;
      end
      S_PRD: begin
        gain <= chan_rd.gain;
        num  <= 44'(diff[23:0]) * 44'(hrc_pkg::PIX_SCALE);
        if (chan_rd.gain == '0) begin
          res.status <= hrc_pkg::ST_INVALID;
        end
      end
      S_PWAIT: begin
        if (div_done) begin
          res.albedo <= (div_quot > hrc_pkg::DIV_W'(hrc_pkg::ALB_MAX))
                        ? 10'(hrc_pkg::ALB_MAX) : div_quot[9:0];
        end
      end
      S_CW0: begin
        if (cmd.wl < ref_rd.wl) begin
          res.status <= hrc_pkg::ST_RANGE;
        end
      end
      S_CWL: begin
        hi <= ref_rd;
        k  <= last - 1'b1;
        if (cmd.wl > ref_rd.wl) begin
          res.status <= hrc_pkg::ST_RANGE;
        end
      end
      S_SCAN: begin
        if (cmd.wl <= hi.wl && cmd.wl >= ref_rd.wl) begin
          lo <= ref_rd;
          j  <= 2'd0;
        end else if (k == '0) begin
          res.status <= hrc_pkg::ST_RANGE;
        end else begin
          hi <= ref_rd;
          k  <= k - 1'b1;
        end
      end
      S_LMUL: begin
        neg  <= dd[32];
        prod <= 48'(dd_abs[31:0]) * 48'(dx);
        if (span == '0) begin
          case (j)
            2'd0:    off_v  <= d0[23:0];
            2'd1:    edir_v <= d0[31:0];
            2'd2:    edn_v  <= d0[31:0];
            default: tau_v  <= d0[15:0];
          endcase
          j <= j + 2'd1;
        end
      end
      S_LWAIT: begin
        if (div_done) begin
          case (j)
            2'd0:    off_v  <= lv[23:0];
            2'd1:    edir_v <= lv[31:0];
            2'd2:    edn_v  <= lv[31:0];
            default: tau_v  <= lv[15:0];
          endcase
          j <= j + 2'd1;
        end
      end
      S_GAIN: begin
        p <= 49'({1'b0, edir_v} + {1'b0, edn_v}) * 49'(tau_v);
      end
      S_GFIN: begin
        if (p == '0) begin
          res.status <= hrc_pkg::ST_INVALID;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/hyperspectral_reflectance_conversion.sv */
// Top level of the hyperspectral reflectance conversion block.
//
// Channels: items enter through push/full (transaction when push && !full),
// results leave through empty/pop (transaction when pop && !empty); every
// item gives exactly one result, in order. An APB write at address 0 sets
// reference_point_count (reset 2); it is read back on prdata.
// Item kinds: load a reference point, set a channel wavelength (bracketing
// search plus linear interpolation of path radiance, irradiances and
// transmittance), and convert a pixel count to albedo * 1000 with status.
// Items are worked one at a time by the back end: a pixel takes at most one
// pass of the shared divider, a channel setup a scan of the reference points
// plus up to four divider passes. A two-entry queue in front lets a new
// item be taken while the back end works; a two-entry result queue lets
// the back end finish while the receiver stalls. A stalled receiver only
// blocks once both fill.
// Reset: synchronous; queues empty, all channels invalid, point count 2.
// The reference table is undefined until loaded.
`default_nettype none
module hyperspectral_reflectance_conversion (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         op,
  input  wire logic [7:0]         index,
  input  wire logic [15:0]        wavelength,
  input  wire logic signed [23:0] path_radiance,
  input  wire logic [31:0]        direct_irradiance,
  input  wire logic [31:0]        diffuse_irradiance,
  input  wire logic [15:0]        transmittance,
  input  wire logic signed [15:0] raw_pixel,
  output logic                    empty,
  input  wire logic               pop,
  output logic      [9:0]         albedo,
  output logic      [1:0]         status
);

  logic [6:0]    ref_count;
  logic          q_valid;
  logic          q_take;
  hrc_pkg::cmd_t q_cmd;
  logic          res_valid;
  logic          res_ready;
  hrc_pkg::res_t res;
  hrc_pkg::res_t oslot [2];
  logic          owr;
  logic          ord;
  logic [1:0]    ocount;
  logic          oput;
  logic          oget;

  // register file: one register, word 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'b0, ref_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= 7'd2;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      ref_count <= pwdata[6:0];
    end
  end

  hrc_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .op                 (op),
    .index              (index),
    .wavelength         (wavelength),
    .path_radiance      (path_radiance),
    .direct_irradiance  (direct_irradiance),
    .diffuse_irradiance (diffuse_irradiance),
    .transmittance      (transmittance),
    .raw_pixel          (raw_pixel),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_take             (q_take)
  );

  hrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ref_count (ref_count),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // result queue
  assign res_ready = ocount != 2'd2;
  assign oput      = res_valid && res_ready;
  assign oget      = pop && !empty;
  assign empty     = ocount == 2'd0;
  assign albedo    = oslot[ord].albedo;
  assign status    = oslot[ord].status;

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (oput) begin
        owr <= !owr;
      end
      if (oget) begin
        ord <= !ord;
      end
      ocount <= ocount + {1'b0, oput} - {1'b0, oget};
    end
  end

  always_ff @(posedge clk) begin
    if (oput) begin
      oslot[owr] <= res;
    end
  end

  // result queue never overflows
  a_ocount: assert property (@(posedge clk) disable iff (rst) ocount != 2'd3)
    else $error("result queue count out of range");

  // albedo stays clamped
  a_albedo: assert property (@(posedge clk) disable iff (rst)
    !empty |-> albedo <= 10'(hrc_pkg::ALB_MAX))
    else $error("albedo above clamp");

  // a failing status never carries an albedo
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != hrc_pkg::ST_OK) |-> albedo == 10'd0)
    else $error("nonzero albedo with failing status");

  // reset leaves the result queue empty and the front queue not full
  a_reset: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule
`default_nettype wire

/* tb/tb_hyperspectral_reflectance_conversion.sv */
// Testbench for the hyperspectral reflectance conversion block.
`default_nettype none
module tb_hyperspectral_reflectance_conversion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [1:0] op = hrc_pkg::OP_NONE;
  logic [7:0] index = '0;
  logic [15:0] wavelength = '0;
  logic signed [23:0] path_radiance = '0;
  logic [31:0] direct_irradiance = '0, diffuse_irradiance = '0;
  logic [15:0] transmittance = '0;
  logic signed [15:0] raw_pixel = '0;
  logic empty;
  logic pop = 1'b0;
  logic [9:0] albedo;
  logic [1:0] status;

  hyperspectral_reflectance_conversion dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: reference table, per-channel calibration, point count
  hrc_pkg::ref_ent_t  tbl [hrc_pkg::REF_DEPTH];
  hrc_pkg::chan_ent_t cal [hrc_pkg::CHANNELS];
  bit                 cal_ok [hrc_pkg::CHANNELS];
  int unsigned        point_count = 2;
  hrc_pkg::res_t      expected_results [$];

  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  rx_stall_on = 1'b1;
  bit  tx_gap_on = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // linear interpolation, quotient truncated toward zero
  function automatic longint interp(longint d0, longint d1, longint x, longint w0, longint w1);
    longint span;
    span = w1 - w0;
    if (span <= 0) return d0;
    return d0 + ((d1 - d0) * (x - w0)) / span;
  endfunction

  function automatic hrc_pkg::status_t calibrate(int ch, int unsigned x);
    int unsigned n;
    int seg;
    longint off, edir, edn, tau;
    logic [63:0] p, g;
    seg = 0;
    cal_ok[ch] = 1'b0;
    cal[ch] = '0;
    n = point_count < 2 ? 2 :
        (point_count > hrc_pkg::REF_DEPTH ? hrc_pkg::REF_DEPTH : point_count);
    if (x < tbl[0].wl || x > tbl[n-1].wl) return hrc_pkg::ST_RANGE;
    for (int i = int'(n) - 1; i > 0; i--)
      if (x <= tbl[i].wl && x >= tbl[i-1].wl) begin
        seg = i;
        break;
      end
    if (seg == 0) return hrc_pkg::ST_RANGE;
    off  = interp(tbl[seg-1].pr, tbl[seg].pr, x, tbl[seg-1].wl, tbl[seg].wl);
    edir = interp(longint'(tbl[seg-1].edir), longint'(tbl[seg].edir), x,
                  tbl[seg-1].wl, tbl[seg].wl);
    edn  = interp(longint'(tbl[seg-1].edn), longint'(tbl[seg].edn), x,
                  tbl[seg-1].wl, tbl[seg].wl);
    tau  = interp(longint'(tbl[seg-1].tau), longint'(tbl[seg].tau), x,
                  tbl[seg-1].wl, tbl[seg].wl);
    p = (64'(edir) + 64'(edn)) * 64'(tau);
    if (p == 0) return hrc_pkg::ST_INVALID;
    g = p >> 16;
    if (g == 0) g = 1;
    if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
    cal[ch].offset = off[23:0];
    cal[ch].gain = g[31:0];
    cal_ok[ch] = 1'b1;
    return hrc_pkg::ST_OK;
  endfunction

  function automatic hrc_pkg::res_t predict(hrc_pkg::cmd_t c);
    hrc_pkg::res_t r;
    longint diff;
    logic [63:0] q;
    r.albedo = '0;
    r.status = hrc_pkg::ST_OK;
    if (c.kind == hrc_pkg::K_LOAD) begin
      if (c.index < hrc_pkg::REF_DEPTH) begin
        tbl[c.index] = '{wl: c.wl, pr: c.pr, edir: c.edir, edn: c.edn, tau: c.tau};
      end
    end else if (c.kind == hrc_pkg::K_CHAN) begin
      r.status = c.index < hrc_pkg::CHANNELS ? calibrate(int'(c.index), c.wl)
                                             : hrc_pkg::ST_INVALID;
    end else if (c.kind == hrc_pkg::K_PIX) begin
      if (c.index >= hrc_pkg::CHANNELS || !cal_ok[c.index] || cal[c.index].gain == 0)
        r.status = hrc_pkg::ST_INVALID;
      else begin
        diff = longint'(c.raw) * 256 - longint'(cal[c.index].offset);
        if (diff > 0) begin
          q = 64'(diff) * 3140 * 256 / 64'(cal[c.index].gain);
          r.albedo = q > 1000 ? 10'd1000 : q[9:0];
        end
      end
    end
    return r;
  endfunction

  // send one transaction; kind selects the op code
  task automatic send(input hrc_pkg::cmd_t c);
    hrc_pkg::op_t o;
    case (c.kind)
      hrc_pkg::K_LOAD: o = hrc_pkg::OP_LOAD;
      hrc_pkg::K_CHAN: o = hrc_pkg::OP_CHAN;
      hrc_pkg::K_PIX:  o = hrc_pkg::OP_PIX;
      default:         o = hrc_pkg::OP_NONE;
    endcase
    if (tx_gap_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    push <= 1'b1;
    op <= o;
    index <= c.index;
    wavelength <= c.wl;
    path_radiance <= c.pr;
    direct_irradiance <= c.edir;
    diffuse_irradiance <= c.edn;
    transmittance <= c.tau;
    raw_pixel <= c.raw;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.insert(expected_results.size(), predict(c));
    @(negedge clk);
  endtask

  task automatic idle_sender();
    push <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    idle_sender();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_point_count(input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    point_count = v & 32'h7F;
    @(negedge clk);
    if (prdata[6:0] !== v[6:0]) report("prdata", prdata, v & 32'h7F);
  endtask

  function automatic hrc_pkg::cmd_t rand_cmd();
    hrc_pkg::cmd_t c;
    c.kind = hrc_pkg::K_NOP;
    c.index = 8'($urandom);
    c.wl = 16'($urandom);
    c.pr = 24'($urandom);
    c.edir = $urandom;
    c.edn = $urandom;
    c.tau = 16'($urandom);
    c.raw = 16'($urandom);
    return c;
  endfunction

  // loads n sorted points with random content; gaps keep wavelengths increasing
  task automatic load_table(input int n, input int wide);
    hrc_pkg::cmd_t c;
    int unsigned w;
    w = $urandom_range(0, 2000);
    for (int i = 0; i < n; i++) begin
      c = rand_cmd();
      c.kind = hrc_pkg::K_LOAD;
      c.index = 8'(i);
      c.wl = 16'(w);
      if (!wide) begin
        c.edir = $urandom_range(0, 32'h00FF_FFFF);
        c.edn = $urandom_range(0, 32'h00FF_FFFF);
        c.pr = $signed(24'($urandom_range(0, 16'hFFFF))) - 24'sd32768;
      end
      send(c);
      w += $urandom_range(1, 900);
    end
  endtask

  function automatic hrc_pkg::cmd_t chan_cmd(input int n);
    hrc_pkg::cmd_t c;
    int hi;
    c = rand_cmd();
    c.kind = hrc_pkg::K_CHAN;
    c.index = 8'($urandom_range(0, 15));
    hi = int'(point_count < 2 ? 2 : point_count) - 1;
    if (hi >= n) hi = n - 1;
    if ($urandom_range(0, 9) != 0)
      c.wl = 16'($urandom_range(tbl[0].wl, tbl[hi].wl));
    return c;
  endfunction

  function automatic hrc_pkg::cmd_t pix_cmd();
    hrc_pkg::cmd_t c;
    c = rand_cmd();
    c.kind = hrc_pkg::K_PIX;
    c.index = 8'($urandom_range(0, 17));
    if ($urandom_range(0, 1)) c.raw = $signed(16'($urandom_range(0, 2000))) - 16'sd200;
    return c;
  endfunction

  // result checking and random receiver stalls
  initial begin
    hrc_pkg::res_t want;
    forever begin
      @(negedge clk);
      if (rx_stall_on && $urandom_range(0, 15) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      pop <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 32'(albedo), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (albedo !== want.albedo) report("albedo", 32'(albedo), 32'(want.albedo));
          if (status !== want.status) report("status", 32'(status), 32'(want.status));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // directed: field extremes, each op, out-of-range and invalid cases
  task automatic test_directed();
    hrc_pkg::cmd_t c;
    c = rand_cmd();
    c.kind = hrc_pkg::K_PIX; c.index = 8'd3; c.raw = 16'sh7FFF; send(c);  // channel not set
    c.kind = hrc_pkg::K_NOP; send(c);
    c.kind = hrc_pkg::K_LOAD; c.index = 8'd255; send(c);                 // ignored load
    c = '{kind: hrc_pkg::K_LOAD, index: 8'd0, wl: 16'd1000, pr: 24'sh800000,
          edir: 32'hFFFF_FFFF, edn: 32'hFFFF_FFFF, tau: 16'hFFFF, raw: 16'sd0};
    send(c);
    c = '{kind: hrc_pkg::K_LOAD, index: 8'd1, wl: 16'd2000, pr: 24'sh7FFFFF, edir: 32'd0,
          edn: 32'd0, tau: 16'd0, raw: 16'sd0};
    send(c);
    c.kind = hrc_pkg::K_CHAN; c.index = 8'd0; c.wl = 16'd999; send(c);   // below table
    c.wl = 16'd2001; send(c);                                           // above table
    c.wl = 16'd2000; send(c);                                           // zero denominator
    c.index = 8'd255; c.wl = 16'd1000; send(c);                         // saturated gain
    c.index = 8'd1; c.wl = 16'd1500; send(c);
    c.kind = hrc_pkg::K_PIX; c.index = 8'd1; c.raw = 16'sh8000; send(c);
    c.raw = 16'sh7FFF; send(c);
    c.index = 8'd255; send(c);
    c.index = 8'd0; send(c);                                            // invalid channel
    // equal wavelengths: lower point wins; tiny denominator gives gain 1
    c = '{kind: hrc_pkg::K_LOAD, index: 8'd1, wl: 16'd1000, pr: 24'sd0, edir: 32'd1,
          edn: 32'd0, tau: 16'd1, raw: 16'sd0};
    send(c);
    c.kind = hrc_pkg::K_CHAN; c.index = 8'd2; send(c);
    c.index = 8'd0; c.wl = 16'd0; send(c);
    c = '{kind: hrc_pkg::K_LOAD, index: 8'd0, wl: 16'd0, pr: 24'sd0, edir: 32'd1,
          edn: 32'd0, tau: 16'd1, raw: 16'sd0};
    send(c);
    c = '{kind: hrc_pkg::K_LOAD, index: 8'd1, wl: 16'hFFFF, pr: 24'sd0, edir: 32'd1,
          edn: 32'd0, tau: 16'd1, raw: 16'sd0};
    send(c);
    c.kind = hrc_pkg::K_CHAN; c.index = 8'd4; c.wl = 16'hFFFF; send(c);
    c.kind = hrc_pkg::K_PIX; c.raw = 16'sd1; send(c);
    c.raw = 16'sd0; send(c);
    drain();
  endtask

  // random sessions: sorted table, channels across it, then mostly pixels
  task automatic test_random(input int items, input int count);
    hrc_pkg::cmd_t c;
    int n;
    write_point_count(32'(count));
    n = count < 2 ? 2 : (count > hrc_pkg::REF_DEPTH ? hrc_pkg::REF_DEPTH : count);
    load_table(n, int'($urandom_range(0, 1)));
    for (int k = 0; k < 10; k++) send(chan_cmd(n));
    for (int k = 0; k < items; k++) begin
      case ($urandom_range(0, 19))
        0: send(chan_cmd(n));
        1: begin
          c = rand_cmd();
          c.kind = hrc_pkg::K_NOP;
          send(c);
        end
        2: begin
          c = rand_cmd();
          c.kind = hrc_pkg::K_PIX;
          c.index = 8'($urandom_range(16, 255));
          send(c);
        end
        default: send(pix_cmd());
      endcase
    end
  endtask

  // sender waits for the pipeline to empty mid-run
  task automatic test_pause();
    test_random(60, 7);
    idle_sender();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) send(pix_cmd());
    drain();
  endtask

  // unsorted table entries and an out-of-range point count
  task automatic test_unsorted();
    hrc_pkg::cmd_t c;
    write_point_count(32'd0);     // acts as two points
    for (int i = 0; i < 4; i++) begin
      c = rand_cmd();
      c.kind = hrc_pkg::K_LOAD;
      c.index = 8'(i);
      c.wl = i == 2 ? 16'd100 : 16'(500 * (i + 1));
      send(c);
    end
    for (int i = 0; i < 8; i++) send(chan_cmd(2));
    drain();
    write_point_count(32'd4);
    for (int i = 0; i < 10; i++) send(chan_cmd(4));
    for (int i = 0; i < 10; i++) send(pix_cmd());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    if (prdata[6:0] !== 7'd2) report("reset point count", prdata, 32'd2);
    test_directed();
    test_random(120, 64);
    drain();
    test_unsorted();
    test_pause();
    test_random(120, 127);   // clipped to the table depth
    drain();
    test_random(100, 3);
    drain();
    // last part with neither side idling
    tx_gap_on = 1'b0;
    rx_stall_on = 1'b0;
    test_random(100, 2);
    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
